// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the archive stream cipher checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ABSC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cipher check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define ABSC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cipher check failed");

`endif

// ===== hw/rtl/absc_pkg.sv =====
// ----------------------------------------------------------------------------
// absc_pkg
// Types, constants and the 256-word key table of the archive stream cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package absc_pkg;

    localparam int unsigned ROM_DEPTH = 256;

    localparam logic [31:0] SEED_INIT  = 32'hEEEE_EEEE;
    localparam logic [31:0] KEY_INIT   = 32'h0000_0000;
    localparam logic [31:0] KEY_ADD    = 32'h1111_1111;
    localparam logic [31:0] SEED_ADD   = 32'h0000_0003;
    localparam logic [31:0] GEN_START  = 32'h0010_0001;
    localparam logic [31:0] GEN_MUL    = 32'd125;
    localparam logic [31:0] GEN_INC    = 32'd3;
    localparam logic [31:0] GEN_MOD    = 32'h002A_AAAB;
    localparam int unsigned GEN_SEGS   = 5;
    localparam int unsigned ROM_SEG    = 4;

    typedef logic [31:0] word_t;
    typedef word_t rom_t [ROM_DEPTH];

    typedef struct packed {
        word_t key;
        word_t seed;
    } state_t;

    function automatic word_t gen_next(input word_t s);
        return (s * GEN_MUL + GEN_INC) % GEN_MOD;
    endfunction

    function automatic rom_t build_rom();
        rom_t  rom;
        word_t s;
        word_t hi;
        s = GEN_START;
        for (int row = 0; row < ROM_DEPTH; row++)
        begin
            for (int seg = 0; seg < GEN_SEGS; seg++)
            begin
                s  = gen_next(s);
                hi = {s[15:0], 16'h0000};
                s  = gen_next(s);
                if (seg == ROM_SEG)
                begin
                    rom[row] = hi | {16'h0000, s[15:0]};
                end
            end
        end
        return rom;
    endfunction

    localparam rom_t CIPHER_ROM = build_rom();

endpackage

`default_nettype wire

// ===== hw/rtl/archive_block_stream_cipher_core.sv =====
// ----------------------------------------------------------------------------
// archive_block_stream_cipher_core
// Word-serial archive block cipher, encrypt or decrypt, one word per cycle unless stalled.
// ----------------------------------------------------------------------------
//   channel  handshake                 payload
//   word     word_valid / word_stall   mode, block_start, block_key, data_in
//   result   result_valid / result_stall  data_out
//
//   One word per cycle sustained while result_stall is low; request and result stages are registered.
//   The running key and seed update once per word, in the result stage.
//   Reset: key 0, seed 0xEEEEEEEE, both stages empty.
//   word_stall rises only while a result is held and result_stall is high.
// ----------------------------------------------------------------------------
`default_nettype none

module archive_block_stream_cipher_core
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        word_valid,
    output logic             word_stall,
    input  wire logic        mode,
    input  wire logic        block_start,
    input  wire logic [31:0] block_key,
    input  wire logic [31:0] data_in,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [31:0]      data_out
);

    logic             in_valid_reg;
    logic             in_mode_reg;
    logic             in_start_reg;
    absc_pkg::word_t  in_key_reg;
    absc_pkg::word_t  in_data_reg;
    logic             out_valid_reg;
    absc_pkg::word_t  out_data_reg;
    absc_pkg::state_t state_reg;

    absc_pkg::state_t state_cur;
    absc_pkg::state_t state_next;
    absc_pkg::word_t  round_result;
    logic             out_ready;
    logic             advance;
    logic             in_take;

    assign out_ready  = !out_valid_reg || !result_stall;
    assign advance    = in_valid_reg && out_ready;
    assign word_stall = in_valid_reg && !out_ready;
    assign in_take    = word_valid && !word_stall;

    always_comb
    begin
        if (in_start_reg)
        begin
            state_cur.key  = in_key_reg;
            state_cur.seed = absc_pkg::SEED_INIT;
        end
        else
        begin
            state_cur = state_reg;
        end
    end

    absc_round u_round
    (
        .mode       (in_mode_reg),
        .data_word  (in_data_reg),
        .state_cur  (state_cur),
        .result     (round_result),
        .state_next (state_next)
    );

    // hold the request while the result stage is blocked
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!word_stall)
        begin
            in_valid_reg <= word_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_mode_reg  <= mode;
            in_start_reg <= block_start;
            in_key_reg   <= block_key;
            in_data_reg  <= data_in;
        end
    end

    // advance key, seed and result together
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            state_reg.key  <= absc_pkg::KEY_INIT;
            state_reg.seed <= absc_pkg::SEED_INIT;
        end
        else
        begin
            if (out_ready)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= round_result;
        end
    end

    assign result_valid = out_valid_reg;
    assign data_out     = out_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/absc_round.sv =====
// ----------------------------------------------------------------------------
// absc_round
// One cipher word: table add, key stream XOR, key shift and mix, seed fold.
// ----------------------------------------------------------------------------
`default_nettype none

module absc_round
(
    input  wire logic             mode,
    input  wire absc_pkg::word_t  data_word,
    input  wire absc_pkg::state_t state_cur,
    output absc_pkg::word_t       result,
    output absc_pkg::state_t      state_next
);

    absc_pkg::word_t seed_mix;
    absc_pkg::word_t plain;

    always_comb
    begin
        seed_mix = state_cur.seed + absc_pkg::CIPHER_ROM[state_cur.key[7:0]];
        result   = data_word ^ (state_cur.key + seed_mix);
        plain    = mode ? data_word : result;
        state_next.key  = (((~state_cur.key) << 21) + absc_pkg::KEY_ADD)
                        | (state_cur.key >> 11);
        state_next.seed = plain + seed_mix + (seed_mix << 5) + absc_pkg::SEED_ADD;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/absc_checker.sv =====
// ----------------------------------------------------------------------------
// absc_checker
// Port-level checks of the archive stream cipher core, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module absc_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        word_valid,
    input wire logic        word_stall,
    input wire logic        result_valid,
    input wire logic        result_stall,
    input wire logic [31:0] data_out
);

    `ABSC_ASSERT_NEXT(a_result_held, result_valid && result_stall, result_valid)
    `ABSC_ASSERT_NEXT(a_result_stable, result_valid && result_stall, $stable(data_out))
    `ABSC_ASSERT_NOW(a_stall_from_result, word_stall, result_valid && result_stall)
    `ABSC_ASSERT_NOW(a_result_from_request, $rose(result_valid), $past(word_valid && !word_stall, 2))

endmodule

bind archive_block_stream_cipher_core absc_checker u_absc_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .word_valid   (word_valid),
    .word_stall   (word_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .data_out     (data_out)
);

`default_nettype wire

// ===== sim/cipher_word_monitor.sv =====
// ----------------------------------------------------------------------------
// cipher_word_monitor
// Watches both channels of the archive stream cipher core. On every accepted
// request it runs its own copy of the running key and seed, with its own key
// table, to predict the output word. Each accepted result is compared with
// the oldest predicted word. Mismatches are counted and handed to the top.
// ----------------------------------------------------------------------------
module cipher_word_monitor
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        word_valid,
    input  logic        word_stall,
    input  logic        mode,
    input  logic        block_start,
    input  logic [31:0] block_key,
    input  logic [31:0] data_in,
    input  logic        result_valid,
    input  logic        result_stall,
    input  logic [31:0] data_out,
    output int unsigned mismatches,
    output int unsigned words_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam absc_pkg::word_t SEED_START   = 32'hEEEE_EEEE;
    localparam absc_pkg::word_t KEY_BIAS     = 32'h1111_1111;
    localparam absc_pkg::word_t LCG_START    = 32'h0010_0001;
    localparam absc_pkg::word_t LCG_MODULUS  = 32'h002A_AAAB;
    localparam int              TABLE_BLOCK  = 4;

    absc_pkg::word_t key_table [256];
    absc_pkg::word_t cipher_key;
    absc_pkg::word_t cipher_seed;
    absc_pkg::word_t expected_words [$];

    initial
    begin
        absc_pkg::word_t s;
        absc_pkg::word_t hi;
        mismatches    = 0;
        words_pending = 0;
        s = LCG_START;
        for (int row = 0; row < 256; row++)
        begin
            for (int blk = 0; blk <= TABLE_BLOCK; blk++)
            begin
                s  = (s * 32'd125 + 32'd3) % LCG_MODULUS;
                hi = s;
                s  = (s * 32'd125 + 32'd3) % LCG_MODULUS;
                if (blk == TABLE_BLOCK)
                begin
                    key_table[row] = {hi[15:0], s[15:0]};
                end
            end
        end
    end

    task automatic report_mismatch(input string what, input absc_pkg::word_t got,
                                   input absc_pkg::word_t want);
        $display("%0t ns: %s: got %h, want %h", $realtime, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        absc_pkg::word_t k;
        absc_pkg::word_t seed;
        absc_pkg::word_t result;
        absc_pkg::word_t plain;
        if (!rst_n)
        begin
            cipher_key  = 32'h0000_0000;
            cipher_seed = SEED_START;
            expected_words.delete();
            words_pending = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    report_mismatch("unexpected result", data_out, 32'h0);
                end
                else
                begin
                    result = expected_words.pop_front();
                    if (data_out !== result)
                    begin
                        report_mismatch("data_out", data_out, result);
                    end
                end
            end
            if (word_valid && !word_stall)
            begin
                if (block_start)
                begin
                    cipher_key  = block_key;
                    cipher_seed = SEED_START;
                end
                k      = cipher_key;
                seed   = cipher_seed + key_table[k[7:0]];
                result = data_in ^ (k + seed);
                plain  = mode ? data_in : result;
                cipher_key  = (((~k) << 21) + KEY_BIAS) | (k >> 11);
                cipher_seed = plain + seed + (seed << 5) + 32'd3;
                expected_words.push_back(result);
            end
            words_pending = expected_words.size();
        end
    end

endmodule

// ===== sim/archive_block_stream_cipher_core_tb.sv =====
// ----------------------------------------------------------------------------
// archive_block_stream_cipher_core_tb
// Drives the archive stream cipher core with a directed set of words (reset
// state, extreme keys and data, mode changes within a block) and then random
// blocks of words with random idling on both sides, including long result
// holds that back the core up. A monitor predicts and checks every word.
// ----------------------------------------------------------------------------
module archive_block_stream_cipher_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned WORD_COUNT = 1900;
    localparam int unsigned LONG_HOLD  = 250;
    localparam int unsigned IDLE_LIMIT = 4000;

    logic        clk;
    logic        rst_n;
    logic        word_valid;
    logic        word_stall;
    logic        mode;
    logic        block_start;
    logic [31:0] block_key;
    logic [31:0] data_in;
    logic        result_valid;
    logic        result_stall;
    logic [31:0] data_out;

    int unsigned mismatches;
    int unsigned words_pending;
    int unsigned words_sent;
    int unsigned steady_left;
    int unsigned idle_cycles;
    bit          tx_calm;
    bit          rx_calm;
    bit          long_hold_pending;

    archive_block_stream_cipher_core DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .word_valid   (word_valid),
        .word_stall   (word_stall),
        .mode         (mode),
        .block_start  (block_start),
        .block_key    (block_key),
        .data_in      (data_in),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .data_out     (data_out)
    );

    cipher_word_monitor u_monitor
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .word_valid    (word_valid),
        .word_stall    (word_stall),
        .mode          (mode),
        .block_start   (block_start),
        .block_key     (block_key),
        .data_in       (data_in),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .data_out      (data_out),
        .mismatches    (mismatches),
        .words_pending (words_pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if ((word_valid && !word_stall) || (result_valid && !result_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_word(input bit enc, input bit start, input logic [31:0] key,
                             input logic [31:0] word);
        int unsigned gap;
        gap = (tx_calm || steady_left > 0) ? 0 : $urandom_range(0, 14);
        if (steady_left > 0)
        begin
            steady_left--;
        end
        if (gap > 0)
        begin
            word_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        mode        <= enc;
        block_start <= start;
        block_key   <= key;
        data_in     <= word;
        word_valid  <= 1'b1;
        do @(posedge clk); while (word_stall);
        @(negedge clk);
        words_sent++;
    endtask

    function automatic logic [31:0] pick_data();
        case ($urandom_range(0, 15))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // receiver: hold off per result, with quiet stretches and long holds
    initial
    begin
        int unsigned hold;
        int unsigned taken;
        result_stall = 1'b0;
        taken = 0;
        @(negedge clk);
        forever
        begin
            if (long_hold_pending)
            begin
                long_hold_pending = 1'b0;
                result_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
            end
            else
            begin
                hold = rx_calm ? 0 : $urandom_range(0, 14);
                if (hold > 0)
                begin
                    result_stall <= 1'b1;
                    repeat (hold) @(negedge clk);
                end
            end
            result_stall <= 1'b0;
            do @(posedge clk); while (!result_valid);
            @(negedge clk);
            taken++;
            if (taken % 37 == 0)
            begin
                rx_calm = ($urandom_range(0, 3) == 0);
            end
        end
    end

    initial
    begin
        int unsigned blen;
        bit          enc;
        bit          flip;
        bit          headless;
        bit          start;
        bit [1:0]    holds_done;
        logic [31:0] key;
        clk               = 1'b0;
        rst_n             = 1'b0;
        word_valid        = 1'b0;
        mode              = 1'b0;
        block_start       = 1'b0;
        block_key         = 32'h0;
        data_in           = 32'h0;
        words_sent        = 0;
        steady_left       = 0;
        idle_cycles       = 0;
        tx_calm           = 1'b0;
        rx_calm           = 1'b0;
        long_hold_pending = 1'b0;
        holds_done        = 2'b00;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // words before any block start run on the reset key and seed
        send_word(1'b1, 1'b0, 32'hFFFF_FFFF, 32'h0000_0000);
        send_word(1'b0, 1'b0, 32'h0000_0000, 32'hFFFF_FFFF);
        send_word(1'b1, 1'b1, 32'h0000_0000, 32'h0000_0000);
        send_word(1'b1, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(1'b1, 1'b0, 32'h0000_0000, 32'h0000_0000);
        send_word(1'b0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(1'b0, 1'b0, 32'hFFFF_FFFF, 32'h0000_0000);
        // mode changes within one block
        send_word(1'b1, 1'b1, 32'h1234_5678, 32'hDEAD_BEEF);
        send_word(1'b0, 1'b0, 32'h0000_0000, 32'hA5A5_A5A5);
        send_word(1'b1, 1'b0, 32'h0000_0000, 32'h5A5A_5A5A);
        send_word(1'b0, 1'b0, 32'h0000_0000, 32'h8000_0000);
        send_word(1'b1, 1'b0, 32'h0000_0000, 32'h0000_0001);
        // key table corners
        send_word(1'b1, 1'b1, 32'h0000_00FF, 32'h0000_0001);
        send_word(1'b0, 1'b1, 32'h0000_0080, 32'h8000_0000);
        send_word(1'b1, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF);
        send_word(1'b0, 1'b1, 32'h0000_0001, 32'hFFFF_FFFE);
        send_word(1'b1, 1'b1, 32'h7FFF_FF00, 32'hFFFF_FFFF);
        send_word(1'b0, 1'b0, 32'hFFFF_FFFF, 32'h0000_0000);

        while (words_sent < WORD_COUNT)
        begin
            blen     = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64)
                                                   : $urandom_range(1, 16);
            tx_calm  = ($urandom_range(0, 4) == 0);
            enc      = $urandom_range(0, 1);
            flip     = ($urandom_range(0, 5) == 0);
            headless = ($urandom_range(0, 19) == 0);
            key      = $urandom();
            if ((!holds_done[0] && words_sent >= 500) || (!holds_done[1] && words_sent >= 1300))
            begin
                holds_done        = {holds_done[0], 1'b1};
                long_hold_pending = 1'b1;
                steady_left       = LONG_HOLD + 50;
            end
            for (int i = 0; i < blen; i++)
            begin
                if (flip)
                begin
                    enc = $urandom_range(0, 1);
                end
                start = (i == 0 && !headless) || ($urandom_range(0, 99) == 0);
                send_word(enc, start, (i == 0) ? key : $urandom(), pick_data());
            end
        end
        word_valid <= 1'b0;

        while (words_pending != 0) @(negedge clk);
        repeat (10) @(negedge clk);
        if (mismatches == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
